@@ sv/tti_pkg.sv @@
`timescale 1ns / 1ps
// tti_pkg: shared constants, breakpoint rom, job word type and rom lookups
// for the thermistor table interpolator. depends on nothing.

package tti_pkg;

    localparam int TABLE_ENTRIES = 50;
    localparam int SAMPLE_BITS   = 10;
    localparam int ROM_POINTS    = 50;
    localparam int READING_SCALE = 10000;

    localparam int ADC_W    = 10;
    localparam int TEMP_W   = 8;
    localparam int SEG_W    = 6;
    localparam int STATUS_W = 2;

    localparam int N_USED = (TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS :
                            ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam int LAST   = N_USED - 1;

    localparam int IDX_W   = $clog2(ROM_POINTS + 1);
    localparam int RAW_W   = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam int SCALE_W = $clog2(READING_SCALE + 1);
    localparam int S_W     = RAW_W + SCALE_W;
    localparam int RD_W    = 24;
    localparam int CMP_W   = (S_W > RD_W) ? S_W : RD_W;
    localparam int CW      = CMP_W + 1;
    localparam int DT_W    = TEMP_W + 1;
    localparam int P1_W    = TEMP_W + RD_W + 1;
    localparam int P2_W    = CW + DT_W;
    localparam int NUM_W   = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
    localparam int QBITS   = TEMP_W;
    localparam int QCNT_W  = $clog2(QBITS + 1);
    localparam int QDEPTH  = 2;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -8'sd128;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 8'sd127;

    typedef enum logic [STATUS_W-1:0] {
        RANGE_INSIDE = 2'd0,
        RANGE_ABOVE  = 2'd1,
        RANGE_CLAMP  = 2'd2
    } t_range;

    typedef struct packed {
        logic [S_W-1:0]   scaled;
        logic [IDX_W-1:0] seg;
        t_range           status;
    } t_job;

    // breakpoint readings in 1/10000 converter counts, strictly descending
    localparam logic [RD_W-1:0] BP_READING [ROM_POINTS] = '{
        24'd10025793, 24'd9875587, 24'd9643300, 24'd9305421, 24'd8844136,
        24'd8563534,  24'd8249348, 24'd7902895, 24'd7527188, 24'd7126531,
        24'd6707021,  24'd6275324, 24'd5838639, 24'd5404084, 24'd4978097,
        24'd4566134,  24'd4172502, 24'd3800265, 24'd3451465, 24'd3127312,
        24'd2828052,  24'd2553540, 24'd2303063, 24'd2075516, 24'd1869913,
        24'd1831306,  24'd1793513, 24'd1756530, 24'd1720337, 24'd1684915,
        24'd1650270,  24'd1616379, 24'd1583247, 24'd1550832, 24'd1519153,
        24'd1488197,  24'd1457935, 24'd1428366, 24'd1399474, 24'd1371258,
        24'd1343701,  24'd1316782, 24'd1290516, 24'd1264864, 24'd1239822,
        24'd1215402,  24'd1191564, 24'd1168317, 24'd1145638, 24'd1123519
    };

    localparam logic signed [TEMP_W-1:0] BP_TEMP [ROM_POINTS] = '{
        -8'sd40, -8'sd30, -8'sd20, -8'sd10, 8'sd0,
        8'sd5,   8'sd10,  8'sd15,  8'sd20,  8'sd25,
        8'sd30,  8'sd35,  8'sd40,  8'sd45,  8'sd50,
        8'sd55,  8'sd60,  8'sd65,  8'sd70,  8'sd75,
        8'sd80,  8'sd85,  8'sd90,  8'sd95,  8'sd100,
        8'sd101, 8'sd102, 8'sd103, 8'sd104, 8'sd105,
        8'sd106, 8'sd107, 8'sd108, 8'sd109, 8'sd110,
        8'sd111, 8'sd112, 8'sd113, 8'sd114, 8'sd115,
        8'sd116, 8'sd117, 8'sd118, 8'sd119, 8'sd120,
        8'sd121, 8'sd122, 8'sd123, 8'sd124, 8'sd125
    };

    function automatic logic [RD_W-1:0] bp_reading_at(input logic [IDX_W-1:0] idx);
        if (idx >= IDX_W'(ROM_POINTS)) begin
            return BP_READING[ROM_POINTS-1];
        end
        return BP_READING[idx];
    endfunction

    function automatic logic [CMP_W-1:0] reading_cmp(input logic [IDX_W-1:0] idx);
        return CMP_W'(bp_reading_at(idx));
    endfunction

    function automatic logic signed [TEMP_W-1:0] bp_temp_at(input logic [IDX_W-1:0] idx);
        if (idx >= IDX_W'(ROM_POINTS)) begin
            return BP_TEMP[ROM_POINTS-1];
        end
        return BP_TEMP[idx];
    endfunction

endpackage

@@ sv/tti_front.sv @@
`timescale 1ns / 1ps
// tti_front: takes a sample, scales it, classifies it against the table ends
// and binary-searches the segment. depends on tti_pkg.

module tti_front import tti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [ADC_W-1:0] i_adc_sample,
    output logic             o_job_push,
    input  logic             i_job_full,
    output t_job             o_job
);

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_CLASS  = 4'b0010,
        F_SEARCH = 4'b0100,
        F_PUSH   = 4'b1000
    } t_front_state;

    t_front_state     r_state, n_state;
    logic [S_W-1:0]   r_s, n_s;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    t_range           r_status, n_status;

    logic [CMP_W-1:0] s_cmp;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;

    assign s_cmp   = CMP_W'(r_s);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IDX_W:1];

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_status = r_status;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_s     = S_W'(i_adc_sample[RAW_W-1:0]) * S_W'(READING_SCALE);
                    n_state = F_CLASS;
                end
            end
            F_CLASS: begin
                priority if (s_cmp <= reading_cmp(IDX_W'(LAST))) begin
                    n_lo     = IDX_W'(LAST);
                    n_status = RANGE_CLAMP;
                    n_state  = F_PUSH;
                end else if (s_cmp > reading_cmp('0)) begin
                    n_lo     = '0;
                    n_status = RANGE_ABOVE;
                    n_state  = F_PUSH;
                end else begin
                    n_lo     = '0;
                    n_hi     = IDX_W'(LAST);
                    n_status = RANGE_INSIDE;
                    n_state  = F_SEARCH;
                end
            end
            F_SEARCH: begin
                if (r_hi - r_lo > IDX_W'(1)) begin
                    if (reading_cmp(mid) >= s_cmp) begin
                        n_lo = mid;
                    end else begin
                        n_hi = mid;
                    end
                end else begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
    end

    assign o_full       = (r_state != F_IDLE);
    assign o_job_push   = (r_state == F_PUSH);
    assign o_job.scaled = r_s;
    assign o_job.seg    = r_lo;
    assign o_job.status = r_status;

    // sample stays bracketed by the search bounds
    a_search_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SEARCH) |-> (reading_cmp(r_lo) >= s_cmp && reading_cmp(r_hi) < s_cmp))
        else $error("search bounds lost the sample");

endmodule

@@ sv/tti_queue.sv @@
`timescale 1ns / 1ps
// tti_queue: short job queue between front and back end.
// depends on tti_pkg.

module tti_queue import tti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    t_job              r_mem [QDEPTH];
    logic [QA_W-1:0]   r_wr, n_wr;
    logic [QA_W-1:0]   r_rd, n_rd;
    logic [QC_W-1:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QC_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QA_W'(QDEPTH - 1)) ? '0 : r_wr + QA_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QA_W'(QDEPTH - 1)) ? '0 : r_rd + QA_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + QC_W'(1);
            2'b01:   n_count = r_count - QC_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QDEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + QC_W'(1)))
        else $error("queue count lost a push");

endmodule

@@ sv/tti_back.sv @@
`timescale 1ns / 1ps
// tti_back: interpolates within the found segment, eight-step restoring
// divide, saturation and the result word register. depends on tti_pkg.

module tti_back import tti_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_empty,
    output logic                       o_job_pop,
    input  t_job                       i_job,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [TEMP_W-1:0]   o_temperature_c,
    output logic [SEG_W-1:0]           o_segment_index,
    output logic [STATUS_W-1:0]        o_range_status
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_SUM  = 6'b000100,
        B_MAG  = 6'b001000,
        B_DIV  = 6'b010000,
        B_DONE = 6'b100000
    } t_back_state;

    localparam logic [QBITS-1:0] Q_NEG_LIMIT = QBITS'(1) << (TEMP_W - 1);
    localparam logic [QBITS-1:0] Q_POS_LIMIT = Q_NEG_LIMIT - QBITS'(1);

    t_back_state              r_state, n_state;
    t_job                     r_job, n_job;
    logic signed [P1_W-1:0]   r_p1, n_p1;
    logic signed [P2_W-1:0]   r_p2, n_p2;
    logic [RD_W-1:0]          r_den, n_den;
    logic signed [NUM_W-1:0]  r_num, n_num;
    logic [NUM_W-1:0]         r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic                     r_ovf, n_ovf;
    logic [NUM_W-1:0]         r_dsh, n_dsh;
    logic [QBITS-1:0]         r_q, n_q;
    logic [QCNT_W-1:0]        r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [TEMP_W-1:0]        r_out_temp, n_out_temp;
    logic [SEG_W-1:0]         r_out_seg, n_out_seg;
    t_range                   r_out_status, n_out_status;

    logic [RD_W-1:0]          a_k, a_k1, den;
    logic signed [TEMP_W-1:0] t_k, t_k1;
    logic signed [CW-1:0]     rd_delta;
    logic signed [DT_W-1:0]   dtemp;
    logic signed [P1_W-1:0]   prod1;
    logic signed [P2_W-1:0]   prod2;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_mag;
    logic [NUM_W-1:0]         lim;
    logic                     div_ge;
    logic [TEMP_W-1:0]        sat_temp;

    assign a_k      = bp_reading_at(r_job.seg);
    assign a_k1     = bp_reading_at(r_job.seg + IDX_W'(1));
    assign t_k      = bp_temp_at(r_job.seg);
    assign t_k1     = bp_temp_at(r_job.seg + IDX_W'(1));
    assign den      = a_k - a_k1;
    assign rd_delta = $signed({1'b0, CMP_W'(a_k)}) - $signed({1'b0, CMP_W'(r_job.scaled)});
    assign dtemp    = DT_W'(t_k1) - DT_W'(t_k);
    assign prod1    = t_k * $signed({1'b0, r_den});
    assign prod2    = rd_delta * dtemp;
    assign num      = NUM_W'(r_p1) + NUM_W'(r_p2);

    assign num_mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign lim     = NUM_W'(r_den) << QBITS;
    assign div_ge  = (r_mag >= r_dsh);

    always_comb begin
        priority if (r_job.status == RANGE_CLAMP) begin
            sat_temp = bp_temp_at(IDX_W'(LAST));
        end else if (r_neg) begin
            sat_temp = (r_ovf || r_q > Q_NEG_LIMIT) ? TEMP_MIN : TEMP_W'('0) - r_q;
        end else begin
            sat_temp = (r_ovf || r_q > Q_POS_LIMIT) ? TEMP_MAX : r_q;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_den        = r_den;
        n_num        = r_num;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_ovf        = r_ovf;
        n_dsh        = r_dsh;
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_temp   = r_out_temp;
        n_out_seg    = r_out_seg;
        n_out_status = r_out_status;
        o_job_pop    = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = (i_job.status == RANGE_CLAMP) ? B_DONE : B_MUL;
                end
            end
            B_MUL: begin
                // den registered here is consumed by the product in the next state
                n_den   = den;
                n_p2    = prod2;
                n_state = B_SUM;
            end
            B_SUM: begin
                n_p1    = prod1;
                n_state = B_MAG;
            end
            B_MAG: begin
                n_num   = num;
                n_state = B_DIV;
                n_cnt   = QCNT_W'(QBITS);
            end
            B_DIV: begin
                priority if (r_cnt == QCNT_W'(QBITS)) begin
                    // first pass only latches the magnitude, sign and overflow and loads the shifted divisor
                    n_mag = num_mag;
                    n_neg = r_num[NUM_W-1];
                    n_ovf = (num_mag >= lim);
                    n_dsh = NUM_W'(r_den) << (QBITS - 1);
                    n_q   = '0;
                    n_cnt = QCNT_W'(QBITS - 1);
                end else begin
                    if (div_ge) begin
                        n_mag = r_mag - r_dsh;
                    end
                    n_q   = {r_q[QBITS-2:0], div_ge};
                    n_dsh = r_dsh >> 1;
                    if (r_cnt == '0) begin
                        n_state = B_DONE;
                    end else begin
                        n_cnt = r_cnt - QCNT_W'(1);
                    end
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid  = 1'b1;
                    n_out_temp   = sat_temp;
                    n_out_seg    = SEG_W'(r_job.seg);
                    n_out_status = r_job.status;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_p1         <= n_p1;
        r_p2         <= n_p2;
        r_den        <= n_den;
        r_num        <= n_num;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_ovf        <= n_ovf;
        r_dsh        <= n_dsh;
        r_q          <= n_q;
        r_cnt        <= n_cnt;
        r_out_temp   <= n_out_temp;
        r_out_seg    <= n_out_seg;
        r_out_status <= n_out_status;
    end

    assign o_empty         = !r_out_valid;
    assign o_temperature_c = $signed(r_out_temp);
    assign o_segment_index = r_out_seg;
    assign o_range_status  = r_out_status;

    // partial remainder stays below twice the shifted divisor
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && r_cnt != QCNT_W'(QBITS) && !r_ovf)
            |-> ({1'b0, r_mag} < {r_dsh, 1'b0}))
        else $error("divider remainder out of range");

    a_no_job_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == B_IDLE && !i_job_empty))
        else $error("job popped while back end busy");

endmodule

@@ sv/thermistor_table_interpolator.sv @@
`timescale 1ns / 1ps
// thermistor_table_interpolator: top level, front search, job queue and back
// end interpolator. depends on tti_pkg, tti_front, tti_queue, tti_back.

// Converts one 10-bit thermistor reading per word into a signed temperature
// in degrees C (truncated toward zero, saturated to -128..127), the segment
// index and a range code (inside, above first breakpoint, clamped at or below
// the last). The front end takes a word, classifies it, then runs up to six
// binary-search steps plus one exit check over the breakpoint rom; a two-word
// queue hands the job to the back end. The back end pops the job, forms the
// two products, sums them, takes the magnitude, runs eight restoring divide
// steps and loads the result register; clamped readings go straight from the
// pop to the result load. It pops a new word only after the last one has
// reached the result register. The result register lets the back end finish
// the next word while a result waits to be popped.

module thermistor_table_interpolator import tti_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [ADC_W-1:0]         i_adc_sample,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [TEMP_W-1:0] o_temperature_c,
    output logic [SEG_W-1:0]         o_segment_index,
    output logic [STATUS_W-1:0]      o_range_status
);

    logic job_push, job_full, job_pop, job_empty;
    t_job job_in, job_out;

    tti_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_adc_sample (i_adc_sample),
        .o_job_push   (job_push),
        .i_job_full   (job_full),
        .o_job        (job_in)
    );

    tti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .o_full  (job_full),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    tti_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_empty     (job_empty),
        .o_job_pop       (job_pop),
        .i_job           (job_out),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_temperature_c (o_temperature_c),
        .o_segment_index (o_segment_index),
        .o_range_status  (o_range_status)
    );

endmodule
